>>> sv/ptbc_pkg.sv
`timescale 1ns / 1ps
// Package for the pan/tilt bilinear calibration core.
// Holds field widths, corner and register indexes, reset values and division constants.
package ptbc_pkg;

  localparam int PosW      = 7;
  localparam int ValW      = 8;
  localparam int WgtW      = 14;
  localparam int NumW      = 22;
  localparam int RecipW    = 23;
  localparam int ProdW     = NumW + RecipW;
  localparam int CfgIdxW   = 8;
  localparam int NumCorners = 4;
  localparam int NumRegs   = 2 * NumCorners;
  localparam int RegIdxW   = 3;
  localparam int NumStages = 5;

  localparam int CornerLt = 0;
  localparam int CornerRt = 1;
  localparam int CornerLb = 2;
  localparam int CornerRb = 3;

  localparam int RegPanBase  = 0;
  localparam int RegTiltBase = NumCorners;

  localparam logic [PosW-1:0]  PctFull   = 7'd100;
  localparam logic [WgtW-1:0]  WeightSum = 14'd10000;
  localparam logic [NumW-1:0]  NumMax    = 22'd2550000;

  // Floor division by 10000 as (num * RecipMul) >> RecipShift, exact for num < 2**22.
  localparam logic [RecipW-1:0] RecipMul  = 23'd6871948;
  localparam int               RecipShift = 36;

  localparam logic [NumRegs-1:0][ValW-1:0] RegReset = {
    8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0
  };

  typedef struct packed {
    logic [NumCorners-1:0][ValW-1:0] pan;
    logic [NumCorners-1:0][ValW-1:0] tilt;
  } corners_t;

endpackage

>>> sv/ptbc_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the pan/tilt bilinear calibration core.
// Depends on ptbc_pkg for the payload widths.
interface ptbc_pos_if;
  logic                       valid;
  logic                       ready;
  logic [ptbc_pkg::PosW-1:0]  pos_x;
  logic [ptbc_pkg::PosW-1:0]  pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface ptbc_res_if;
  logic                       valid;
  logic                       ready;
  logic [ptbc_pkg::ValW-1:0]  pan_value;
  logic [ptbc_pkg::ValW-1:0]  tilt_value;
  modport source (output valid, output pan_value, output tilt_value, input ready);
  modport sink   (input valid, input pan_value, input tilt_value, output ready);
endinterface

interface ptbc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ptbc_pkg::CfgIdxW-1:0] index;
  logic [ptbc_pkg::ValW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/ptbc_cfg_regs.sv
`timescale 1ns / 1ps
// Corner register file of the pan/tilt bilinear calibration core.
// Depends on ptbc_pkg and the ptbc_cfg_if interface.
module ptbc_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptbc_cfg_if.sink           cfg_i,
  output ptbc_pkg::corners_t corners_o
);
  import ptbc_pkg::*;

  logic [NumRegs-1:0][ValW-1:0] regs_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegReset;
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_i.index[RegIdxW-1:0]] <= cfg_i.data;
    end
  end

  assign corners_o.pan  = regs_q[RegPanBase +: NumCorners];
  assign corners_o.tilt = regs_q[RegTiltBase +: NumCorners];

endmodule

>>> sv/pan_tilt_bilinear_calibration_core.sv
`timescale 1ns / 1ps
// Top level of the pan/tilt bilinear calibration core: a five-stage interpolation pipeline.
// Depends on ptbc_pkg, the channel interfaces and ptbc_cfg_regs.
//
//   channel  dir  payload                  role
//   pos_i    in   pos_x, pos_y             target position in percent
//   res_o    out  pan_value, tilt_value    calibrated pan and tilt
//   cfg_i    in   index, data              corner register writes
//
// One position is taken per cycle while the output is not stalled; its result is registered in each stage in turn.
// The stages are clamp, weights, corner products, sums and reciprocal multiply.
// Each stage has its own ready, so a stalled output holds only the stages that are full.
// Reset clears the stage valid bits and loads the corner registers with their defaults.
module pan_tilt_bilinear_calibration_core (
  input logic        clk_i,
  input logic        rst_ni,
  ptbc_pos_if.sink   pos_i,
  ptbc_res_if.source res_o,
  ptbc_cfg_if.sink   cfg_i
);
  import ptbc_pkg::*;

  corners_t corners;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  logic [PosW-1:0] s1_x_q, s1_y_q, s1_ix_q, s1_iy_q;
  logic [PosW-1:0] x_cl, y_cl;

  logic [NumCorners-1:0][WgtW-1:0] s2_w_q;
  logic [NumCorners-1:0][NumW-1:0] s3_pan_q, s3_tilt_q;
  logic [NumW-1:0]                 s4_pan_q, s4_tilt_q;
  logic [ProdW-1:0]                pan_prod, tilt_prod;
  logic [ValW-1:0]                 s5_pan_q, s5_tilt_q;

  ptbc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .corners_o (corners)
  );

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || res_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign pos_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pos_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign x_cl = (pos_i.pos_x > PctFull) ? PctFull : pos_i.pos_x;
  assign y_cl = (pos_i.pos_y > PctFull) ? PctFull : pos_i.pos_y;

  assign pan_prod  = ProdW'(s4_pan_q) * ProdW'(RecipMul);
  assign tilt_prod = ProdW'(s4_tilt_q) * ProdW'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (adv[0] && pos_i.valid) begin
      s1_x_q  <= x_cl;
      s1_y_q  <= y_cl;
      s1_ix_q <= PctFull - x_cl;
      s1_iy_q <= PctFull - y_cl;
    end
    if (adv[1] && vld_q[0]) begin
      s2_w_q[CornerLt] <= WgtW'(s1_ix_q) * WgtW'(s1_iy_q);
      s2_w_q[CornerRt] <= WgtW'(s1_x_q) * WgtW'(s1_iy_q);
      s2_w_q[CornerLb] <= WgtW'(s1_ix_q) * WgtW'(s1_y_q);
      s2_w_q[CornerRb] <= WgtW'(s1_x_q) * WgtW'(s1_y_q);
    end
    if (adv[2] && vld_q[1]) begin
      for (int c = 0; c < NumCorners; c++) begin
        s3_pan_q[c]  <= NumW'(s2_w_q[c]) * NumW'(corners.pan[c]);
        s3_tilt_q[c] <= NumW'(s2_w_q[c]) * NumW'(corners.tilt[c]);
      end
    end
    if (adv[3] && vld_q[2]) begin
      s4_pan_q  <= s3_pan_q[CornerLt] + s3_pan_q[CornerRt]
                 + s3_pan_q[CornerLb] + s3_pan_q[CornerRb];
      s4_tilt_q <= s3_tilt_q[CornerLt] + s3_tilt_q[CornerRt]
                 + s3_tilt_q[CornerLb] + s3_tilt_q[CornerRb];
    end
    if (adv[4] && vld_q[3]) begin
      s5_pan_q  <= pan_prod[RecipShift +: ValW];
      s5_tilt_q <= tilt_prod[RecipShift +: ValW];
    end
  end

  assign res_o.valid      = vld_q[NumStages-1];
  assign res_o.pan_value  = s5_pan_q;
  assign res_o.tilt_value = s5_tilt_q;

  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (s1_x_q <= PctFull) && (s1_y_q <= PctFull)
                 && (s1_ix_q == PctFull - s1_x_q))
    else $error("clamped position out of range");

  a_weight_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (16'(s2_w_q[CornerLt]) + 16'(s2_w_q[CornerRt])
                  + 16'(s2_w_q[CornerLb]) + 16'(s2_w_q[CornerRb])) == 16'(WeightSum))
    else $error("corner weights do not sum to full scale");

  a_num_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (s4_pan_q <= NumMax) && (s4_tilt_q <= NumMax))
    else $error("numerator exceeds the reciprocal range");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && !adv[2]) |=> $stable(s3_pan_q) && $stable(s3_tilt_q) && vld_q[2])
    else $error("stalled product stage changed");

endmodule
